>>> hw/rtl/looped_sample_player_core_assert.svh
// Assertion macros shared by the RTL. Each expects signals named clock and reset in scope.
`ifndef LOOPED_SAMPLE_PLAYER_CORE_ASSERT_SVH
`define LOOPED_SAMPLE_PLAYER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/lsp_pkg.sv
package lsp_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int PTR_W      = 12;
   localparam int LEN_W      = 13;
   localparam int CNT_W      = 4;
   localparam int CNT_EXT_W  = 5;
   localparam int CHAN_W     = 3;
   localparam int REPEAT_W   = 16;
   localparam int EXT_W      = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_TAP   = 2'd1;
   localparam logic [1:0] ACT_FRAME = 2'd2;

   // Register select is byte address bit 2.
   localparam int          REG_SEL_BIT       = 2;
   localparam logic        REG_CHANNEL_COUNT = 1'b0;
   localparam logic        REG_WAVE_LENGTH   = 1'b1;

   localparam logic [CNT_W-1:0] CHANNEL_COUNT_RESET = 4'd1;
   localparam logic [LEN_W-1:0] WAVE_LENGTH_RESET   = 13'd4096;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Frame handed from the read stage to the result serialiser.
   typedef struct packed {
      logic             valid;
      sample_type       sample;
      logic [CNT_W-1:0] count;
   } emit_load_type;

endpackage

>>> hw/rtl/lsp_channels.sv
interface lsp_req_if;
   import lsp_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic [PTR_W-1:0]    sample_index;
   sample_type          sample_value;
   logic                tap_on;
   logic                with_count;
   logic [REPEAT_W-1:0] repeat_count;
   logic                block_start;

   modport source (output valid, action, sample_index, sample_value, tap_on, with_count,
                   repeat_count, block_start, input ready);
   modport sink (input valid, action, sample_index, sample_value, tap_on, with_count,
                 repeat_count, block_start, output ready);
endinterface

interface lsp_rsp_if;
   import lsp_pkg::*;

   logic              valid;
   logic              ready;
   sample_type        sample_out;
   logic [CHAN_W-1:0] channel_index;
   logic              last_channel;

   modport source (output valid, sample_out, channel_index, last_channel, input ready);
   modport sink (input valid, sample_out, channel_index, last_channel, output ready);
endinterface

>>> hw/rtl/looped_sample_player_core.sv
// Load and tap words give no result; they are accepted every cycle unless a frame is
// already waiting in the read stage for the result serialiser.
// A frame word is held in the read stage during the wave memory read, then moves to the
// result register, from which one result word per channel goes out per cycle while the
// receiver is ready; the serialiser takes the next frame only as the last word is taken.
// Reset is synchronous and active high; it restores the register and playback state,
// but the wave memory is not cleared and must be loaded before it is played.
module looped_sample_player_core #(
   parameter int MAX_WAVE_FRAMES = 4096,
   parameter int MAX_CHANNELS    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   lsp_req_if.sink                           req_chan,
   lsp_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lsp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lsp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lsp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import lsp_pkg::*;

`include "looped_sample_player_core_assert.svh"

   localparam int                   ADDR_W       = $clog2(MAX_WAVE_FRAMES);
   localparam logic [EXT_W-1:0]     FRAMES_EXT   = EXT_W'(MAX_WAVE_FRAMES);
   localparam logic [CNT_EXT_W-1:0] CHANNELS_EXT = CNT_EXT_W'(MAX_CHANNELS);

   // ---------------------------------------------------------------------------------------
   // Configuration registers. A write lands at the access cycle; pready is tied high.
   // ---------------------------------------------------------------------------------------
   logic             csr_write;
   logic [CNT_W-1:0] channel_count_ff, channel_count_in;
   logic [LEN_W-1:0] wave_length_ff, wave_length_in;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      channel_count_in = channel_count_ff;
      wave_length_in   = wave_length_ff;
      if (csr_write) begin
         if (paddr[REG_SEL_BIT] == REG_CHANNEL_COUNT) begin
            channel_count_in = pwdata[CNT_W-1:0];
         end else begin
            wave_length_in = pwdata[LEN_W-1:0];
         end
      end
   end

   assign prdata = (paddr[REG_SEL_BIT] == REG_WAVE_LENGTH) ? CSR_DATA_W'(wave_length_ff)
                                                           : CSR_DATA_W'(channel_count_ff);

   // Effective settings: zero is taken as one and anything above the build limit is clamped.
   logic [EXT_W-1:0] len_eff;
   logic [CNT_W-1:0] cnt_eff;

   always_comb begin
      if (wave_length_ff == '0) begin
         len_eff = EXT_W'(1);
      end else if (EXT_W'(wave_length_ff) > FRAMES_EXT) begin
         len_eff = FRAMES_EXT;
      end else begin
         len_eff = EXT_W'(wave_length_ff);
      end
      if (channel_count_ff == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (CNT_EXT_W'(channel_count_ff) > CHANNELS_EXT) begin
         cnt_eff = CHANNELS_EXT[CNT_W-1:0];
      end else begin
         cnt_eff = channel_count_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input decode. Every word is taken in the cycle it is accepted; only a frame moves on.
   // ---------------------------------------------------------------------------------------
   logic req_fire, is_load, is_tap, is_frame;
   logic s1_valid_ff, s1_valid_in;
   logic s1_use_ff, s1_use_in;
   logic [CNT_W-1:0] s1_count_ff, s1_count_in;
   logic emit_free, s1_move;

   assign s1_move        = s1_valid_ff && emit_free;
   assign req_chan.ready = !s1_valid_ff || emit_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign is_load        = req_chan.action == ACT_LOAD;
   assign is_tap         = req_chan.action == ACT_TAP;
   assign is_frame       = req_chan.action == ACT_FRAME;

   // ---------------------------------------------------------------------------------------
   // Playback state. Taps and frames update it in acceptance order, so a following word
   // always sees what the previous one left behind.
   // ---------------------------------------------------------------------------------------
   logic [PTR_W-1:0]    read_pointer_ff, read_pointer_in;
   logic [REPEAT_W-1:0] repeats_done_ff, repeats_done_in;
   logic [REPEAT_W-1:0] repeat_limit_ff, repeat_limit_in;
   logic                playing_ff, playing_in;
   logic                block_silent_ff, block_silent_in;
   logic [PTR_W:0]      ptr_next;
   logic [EXT_W-1:0]    ptr_ext;
   logic [REPEAT_W-1:0] done_sat;
   logic                silent_now, frame_play, ptr_in_range;

   assign ptr_next     = {1'b0, read_pointer_ff} + (PTR_W + 1)'(1);
   assign ptr_ext      = EXT_W'(read_pointer_ff);
   assign ptr_in_range = ptr_ext < FRAMES_EXT;
   // The repeat counter sticks at its maximum.
   assign done_sat     = (repeats_done_ff == '1) ? repeats_done_ff
                                                 : repeats_done_ff + REPEAT_W'(1);

   always_comb begin
      read_pointer_in = read_pointer_ff;
      repeats_done_in = repeats_done_ff;
      repeat_limit_in = repeat_limit_ff;
      playing_in      = playing_ff;
      block_silent_in = block_silent_ff;
      silent_now      = req_chan.block_start ? 1'b0 : block_silent_ff;
      frame_play      = 1'b0;
      if (req_fire && is_tap) begin
         playing_in = req_chan.tap_on;
         if (req_chan.with_count) begin
            repeats_done_in = '0;
            repeat_limit_in = req_chan.repeat_count;
         end
      end
      if (req_fire && is_frame) begin
         block_silent_in = silent_now;
         if (playing_ff && !silent_now) begin
            frame_play = 1'b1;
            // A wrap silences the rest of the callback block and, if a repeat limit is set,
            // counts one repeat. A pointer left beyond a shortened wave also wraps here.
            if (EXT_W'(ptr_next) >= len_eff) begin
               read_pointer_in = '0;
               block_silent_in = 1'b1;
               if (repeat_limit_ff != '0) begin
                  repeats_done_in = done_sat;
                  if (done_sat >= repeat_limit_ff) begin
                     playing_in = 1'b0;
                  end
               end
            end else begin
               read_pointer_in = ptr_next[PTR_W-1:0];
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Wave memory: one write port for loads, one registered read port for frames. A load
   // is written at its acceptance edge, so a frame accepted later reads the new sample.
   // The read register only moves when a frame is accepted, which holds it while the
   // read stage waits for the serialiser.
   // ---------------------------------------------------------------------------------------
   logic [SAMPLE_W-1:0] wave_mem [MAX_WAVE_FRAMES];
   logic [EXT_W-1:0]    load_ext;
   logic                mem_wr, mem_rd;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   sample_type          mem_rdata_ff;

   assign load_ext  = EXT_W'(req_chan.sample_index);
   assign mem_wr    = req_fire && is_load && (load_ext < FRAMES_EXT);
   assign mem_waddr = load_ext[ADDR_W-1:0];
   assign mem_rd    = req_fire && is_frame;
   assign mem_raddr = ptr_ext[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         wave_mem[mem_waddr] <= req_chan.sample_value;
      end
      if (mem_rd) begin
         mem_rdata_ff <= sample_type'(wave_mem[mem_raddr]);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Read stage: holds one frame while the memory data arrives and until the serialiser
   // can take it. A silent frame, or a pointer outside the memory, plays zero.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_use_in   = s1_use_ff;
      s1_count_in = s1_count_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire && is_frame) begin
         s1_valid_in = 1'b1;
         s1_use_in   = frame_play && ptr_in_range;
         s1_count_in = cnt_eff;
      end
   end

   emit_load_type emit_load;

   assign emit_load.valid  = s1_move;
   assign emit_load.sample = s1_use_ff ? mem_rdata_ff : sample_type'(0);
   assign emit_load.count  = s1_count_ff;

   lsp_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (emit_load),
      .free     (emit_free),
      .rsp_chan (rsp_chan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CHANNEL_COUNT_RESET;
         wave_length_ff   <= WAVE_LENGTH_RESET;
         read_pointer_ff  <= '0;
         repeats_done_ff  <= '0;
         repeat_limit_ff  <= '0;
         playing_ff       <= 1'b0;
         block_silent_ff  <= 1'b0;
         s1_valid_ff      <= 1'b0;
      end else begin
         channel_count_ff <= channel_count_in;
         wave_length_ff   <= wave_length_in;
         read_pointer_ff  <= read_pointer_in;
         repeats_done_ff  <= repeats_done_in;
         repeat_limit_ff  <= repeat_limit_in;
         playing_ff       <= playing_in;
         block_silent_ff  <= block_silent_in;
         s1_valid_ff      <= s1_valid_in;
      end
      s1_use_ff   <= s1_use_in;
      s1_count_ff <= s1_count_in;
   end

   // ---------------------------------------------------------------------------------------
   // Checks. After a wrap, a frame that does not open a new callback block must be silent;
   // playback may only stop because of an accepted word; a frame waiting in the read stage
   // is started on channel zero straight after the previous frame's last word.
   // ---------------------------------------------------------------------------------------
   `LSP_ASSERT_NEXT(a_silent_after_wrap,
      req_fire && is_frame && !req_chan.block_start && block_silent_ff,
      s1_valid_ff && !s1_use_ff, "frame after a wrap was not silent")
   `LSP_ASSERT_NOW(a_stop_needs_word, $fell(playing_ff), $past(req_fire),
      "playback stopped without an accepted word")
   `LSP_ASSERT_NEXT(a_frame_handoff,
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last_channel && s1_valid_ff,
      rsp_chan.valid && (rsp_chan.channel_index == '0), "waiting frame was not started")

endmodule

>>> hw/rtl/lsp_emit.sv
module lsp_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  lsp_pkg::emit_load_type load,
   output logic                  free,
   lsp_rsp_if.source             rsp_chan
);
   import lsp_pkg::*;

   logic             busy_ff, busy_in;
   sample_type       sample_ff, sample_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] chan_ff, chan_in;
   logic             last;

   // The final channel of a frame is the one whose successor equals the count.
   assign last = (chan_ff + CNT_W'(1)) == count_ff;
   assign free = !busy_ff || (rsp_chan.ready && last);

   always_comb begin
      busy_in   = busy_ff;
      sample_in = sample_ff;
      count_in  = count_ff;
      chan_in   = chan_ff;
      if (load.valid) begin
         busy_in   = 1'b1;
         sample_in = load.sample;
         count_in  = load.count;
         chan_in   = '0;
      end else if (busy_ff && rsp_chan.ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            chan_in = chan_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      sample_ff <= sample_in;
      count_ff  <= count_in;
      chan_ff   <= chan_in;
   end

   assign rsp_chan.valid         = busy_ff;
   assign rsp_chan.sample_out    = sample_ff;
   assign rsp_chan.channel_index = chan_ff[CHAN_W-1:0];
   assign rsp_chan.last_channel  = last;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lsp_pkg::*;

   // Sizes the block is built with; the predictor uses the same figures.
   localparam int WAVE_DEPTH    = 4096;
   localparam int CHANNEL_LIMIT = 8;

   // The one action code that the package leaves unnamed; the block must ignore it.
   localparam logic [1:0] ACT_NONE = 2'd3;

   // Cycles allowed after the last expected word, so that trailing load and tap words settle.
   localparam int SETTLE_CYCLES = 12;
   // Far above the slowest correct run: a few hundred frames of eight channels each,
   // with both sides idling half of the time, plus the drains between phases.
   localparam int CYCLE_LIMIT   = 400000;

   // One input word as the sender sees it.
   typedef struct {
      logic [1:0]          action;
      logic [PTR_W-1:0]    index;
      sample_type          value;
      logic                tap_on;
      logic                with_count;
      logic [REPEAT_W-1:0] repeat_count;
      logic                block_start;
   } player_word_type;

   // One channel result word of a rendered frame.
   typedef struct {
      sample_type        sample;
      logic [CHAN_W-1:0] channel;
      logic              last;
   } channel_word_type;

   logic clock;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lsp_req_if req_bus ();
   lsp_rsp_if rsp_bus ();

   looped_sample_player_core #(
      .MAX_WAVE_FRAMES(WAVE_DEPTH),
      .MAX_CHANNELS   (CHANNEL_LIMIT)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Words waiting to be offered, and channel words the block still owes us.
   player_word_type  queued_words[$];
   channel_word_type owed_channel_words[$];

   // Our own copy of the player: configuration first, then playback state.
   logic [CNT_W-1:0]    cfg_channels;
   logic [LEN_W-1:0]    cfg_length;
   sample_type          wave_copy [WAVE_DEPTH];
   logic [PTR_W-1:0]    play_ptr;
   logic [REPEAT_W-1:0] loops_done;
   logic [REPEAT_W-1:0] loop_limit;
   logic                playing;
   logic                block_silent;

   // Idling odds, in per cent, for the phase under way.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // Bookkeeping that keeps the read pointer on written memory. The pointer can advance
   // by at most one per frame, so it never exceeds the number of frames queued before;
   // the wave memory is filled in order just ahead of that count.
   int fill_next;
   int frames_queued;

   int          fail_count;
   int unsigned cycle_count;

   player_word_type  offer_word;
   player_word_type  seen_word;
   channel_word_type due_word;

   // The clock starts low and has a period of 10 ns.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a hung block must not hang the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Every failure goes through here: one line each, and a count.
   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      fail_count++;
   endtask

   // Predictor: applies one accepted word to our copy of the player and queues the channel
   // words that a frame must produce.
   task automatic play_word(input player_word_type w);
      int               n_chan;
      int               eff_len;
      logic [LEN_W-1:0] next_ptr;
      sample_type       heard;
      channel_word_type cw;

      case (w.action)
         ACT_LOAD: begin
            wave_copy[w.index] = w.value;
         end
         ACT_TAP: begin
            playing = w.tap_on;
            if (w.with_count) begin
               loops_done = '0;
               loop_limit = w.repeat_count;
            end
         end
         ACT_FRAME: begin
            // Out-of-range settings are clamped rather than rejected.
            if (cfg_channels == 0) n_chan = 1;
            else if (cfg_channels > CHANNEL_LIMIT) n_chan = CHANNEL_LIMIT;
            else n_chan = cfg_channels;
            if (cfg_length == 0) eff_len = 1;
            else if (cfg_length > WAVE_DEPTH) eff_len = WAVE_DEPTH;
            else eff_len = cfg_length;

            heard = '0;
            if (w.block_start) block_silent = 1'b0;
            if (playing && !block_silent) begin
               heard = wave_copy[play_ptr];
               next_ptr = {1'b0, play_ptr} + 1'b1;
               // A pointer left beyond a shortened wave wraps here just as at the end.
               if (next_ptr >= eff_len) begin
                  next_ptr = '0;
                  block_silent = 1'b1;
                  if (loop_limit != 0) begin
                     if (loops_done != '1) loops_done = loops_done + 1'b1;
                     if (loops_done >= loop_limit) playing = 1'b0;
                  end
               end
               play_ptr = next_ptr[PTR_W-1:0];
            end

            for (int j = 0; j < n_chan; j++) begin
               cw.sample  = heard;
               cw.channel = CHAN_W'(j);
               cw.last    = (j == n_chan - 1);
               owed_channel_words.push_back(cw);
            end
         end
         default: ;
      endcase
   endtask

   // A word of the given action with every field random; callers override what matters.
   function automatic player_word_type fresh_word(input logic [1:0] act);
      player_word_type w;
      w.action       = act;
      w.index        = PTR_W'($urandom);
      w.value        = SAMPLE_W'($urandom);
      w.tap_on       = 1'($urandom);
      w.with_count   = 1'($urandom);
      w.repeat_count = REPEAT_W'($urandom);
      w.block_start  = 1'($urandom);
      return w;
   endfunction

   // Queues a word for the driver. Ahead of each frame the next unwritten address is loaded
   // if the read pointer could possibly reach it.
   task automatic queue_word(input player_word_type w);
      player_word_type fill;
      if (w.action == ACT_FRAME) begin
         if (fill_next < WAVE_DEPTH && fill_next <= frames_queued) begin
            fill = fresh_word(ACT_LOAD);
            fill.index = PTR_W'(fill_next);
            queued_words.push_back(fill);
            fill_next++;
         end
         frames_queued++;
      end
      if (w.action == ACT_LOAD && w.index == PTR_W'(fill_next)) fill_next++;
      queued_words.push_back(w);
   endtask

   task automatic queue_load(input int idx, input sample_type value);
      player_word_type w;
      w = fresh_word(ACT_LOAD);
      w.index = PTR_W'(idx);
      w.value = value;
      queue_word(w);
   endtask

   task automatic queue_tap(input logic on, input logic counted, input logic [15:0] limit);
      player_word_type w;
      w = fresh_word(ACT_TAP);
      w.tap_on       = on;
      w.with_count   = counted;
      w.repeat_count = limit;
      queue_word(w);
   endtask

   task automatic queue_frame(input logic first);
      player_word_type w;
      w = fresh_word(ACT_FRAME);
      w.block_start = first;
      queue_word(w);
   endtask

   // Random stimulus. Most of it is a callback block of frames, half of the time after a tap
   // that starts playback; the rest is stray loads, taps and frames, plus the odd unused action.
   task automatic queue_random_words(input int count);
      int made;
      int blk;
      int pick;
      player_word_type w;

      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            if ($urandom_range(1) == 1) begin
               // Mostly short loop limits so that playback really does stop now and then.
               queue_tap(1'b1, 1'($urandom),
                         ($urandom_range(3) == 0) ? REPEAT_W'($urandom)
                                                  : REPEAT_W'($urandom_range(4)));
               made++;
            end
            blk = $urandom_range(1, 6);
            for (int j = 0; j < blk; j++) begin
               queue_frame(j == 0);
               made++;
            end
         end else if (pick < 70) begin
            queue_word(fresh_word(ACT_LOAD));
            made++;
         end else if (pick < 80) begin
            queue_word(fresh_word(ACT_TAP));
            made++;
         end else if (pick < 93) begin
            queue_word(fresh_word(ACT_FRAME));
            made++;
         end else begin
            // Ignored by the block, so it does not count towards the total.
            queue_word(fresh_word(ACT_NONE));
         end
      end
   endtask

   // Waits until every queued word has gone in and every owed word has come out, then
   // a little longer for any load or tap still in the pipeline. The check is made at the
   // falling edge, where the driver's and the monitor's updates have all settled.
   task automatic wait_for_quiet();
      do @(negedge clock);
      while (queued_words.size() != 0 || req_bus.valid || owed_channel_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write over the configuration port: a setup cycle, then an access cycle
   // held until pready. Our copy of the register follows at once, as the block is idle.
   task automatic write_register(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(reg_sel) << REG_SEL_BIT;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == REG_CHANNEL_COUNT) cfg_channels = value[CNT_W-1:0];
      else cfg_length = value[LEN_W-1:0];
   endtask

   task automatic enter_phase(input int channels, input int length,
                              input int unsigned idle_pct, input int unsigned stall_pct);
      wait_for_quiet();
      write_register(REG_CHANNEL_COUNT, CSR_DATA_W'(channels));
      write_register(REG_WAVE_LENGTH, CSR_DATA_W'(length));
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      // Fill the queue away from the rising edge, where the driver takes from it.
      @(negedge clock);
   endtask

   // Driver: offers the next queued word whenever the channel is free, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offer_word = queued_words.pop_front();
            req_bus.action       <= offer_word.action;
            req_bus.sample_index <= offer_word.index;
            req_bus.sample_value <= offer_word.value;
            req_bus.tap_on       <= offer_word.tap_on;
            req_bus.with_count   <= offer_word.with_count;
            req_bus.repeat_count <= offer_word.repeat_count;
            req_bus.block_start  <= offer_word.block_start;
            req_bus.valid        <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls the result channel at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: checks each result word against the oldest one owed, then feeds any word
   // accepted at the same edge to the predictor. Doing both in one process keeps the
   // order fixed; a frame's first result comes only after the read stage and result register.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (owed_channel_words.size() == 0) begin
               report_mismatch($sformatf("unexpected result word: sample %0d channel %0d",
                                         rsp_bus.sample_out, rsp_bus.channel_index));
            end else begin
               due_word = owed_channel_words.pop_front();
               if (rsp_bus.sample_out !== due_word.sample)
                  report_mismatch($sformatf("sample_out %0d, expected %0d (channel %0d)",
                                            rsp_bus.sample_out, due_word.sample,
                                            due_word.channel));
               if (rsp_bus.channel_index !== due_word.channel)
                  report_mismatch($sformatf("channel_index %0d, expected %0d",
                                            rsp_bus.channel_index, due_word.channel));
               if (rsp_bus.last_channel !== due_word.last)
                  report_mismatch($sformatf("last_channel %0b, expected %0b (channel %0d)",
                                            rsp_bus.last_channel, due_word.last,
                                            due_word.channel));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_word.action       = req_bus.action;
            seen_word.index        = req_bus.sample_index;
            seen_word.value        = req_bus.sample_value;
            seen_word.tap_on       = req_bus.tap_on;
            seen_word.with_count   = req_bus.with_count;
            seen_word.repeat_count = req_bus.repeat_count;
            seen_word.block_start  = req_bus.block_start;
            play_word(seen_word);
         end
      end
   end

   initial begin
      // Everything the block sees is known from time zero.
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_LOAD;
      req_bus.sample_index = '0;
      req_bus.sample_value = '0;
      req_bus.tap_on       = 1'b0;
      req_bus.with_count   = 1'b0;
      req_bus.repeat_count = '0;
      req_bus.block_start  = 1'b0;
      rsp_bus.ready        = 1'b0;

      cfg_channels   = CHANNEL_COUNT_RESET;
      cfg_length     = WAVE_LENGTH_RESET;
      play_ptr       = '0;
      loops_done     = '0;
      loop_limit     = '0;
      playing        = 1'b0;
      block_silent   = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fill_next      = 0;
      frames_queued  = 0;
      fail_count     = 0;
      cycle_count    = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, at the reset settings of one channel and the full wave length.
      // The first samples are the extremes of the Q1.15 range and minus one.
      queue_load(0, 16'sh7FFF);
      queue_load(1, 16'sh8000);
      queue_load(2, 16'shFFFF);
      queue_load(3, 16'sh0001);
      queue_load(WAVE_DEPTH - 1, 16'sh5A5A);
      queue_frame(1'b1);                  // not playing yet, so a zero
      queue_word(fresh_word(ACT_NONE));   // the unused action must vanish
      queue_tap(1'b1, 1'b0, 16'd0);
      queue_frame(1'b1);
      queue_frame(1'b0);
      queue_frame(1'b0);

      // The pointer now sits at three; shortening the wave to three leaves it beyond the
      // end, so the next frame plays that sample and wraps. Channel count 15 means eight.
      enter_phase(15, 3, 0, 0);
      queue_frame(1'b0);
      queue_frame(1'b0);                  // rest of the block is silent after the wrap
      queue_frame(1'b1);                  // a new block clears the silence
      queue_tap(1'b1, 1'b1, 16'd2);       // stop after two more wraps
      queue_frame(1'b0);
      queue_frame(1'b0);
      queue_frame(1'b1);
      queue_frame(1'b0);
      queue_frame(1'b0);
      queue_frame(1'b1);                  // limit reached: silence from here
      queue_tap(1'b0, 1'b1, 16'hFFFF);

      // Zero for both registers: one channel and a one-frame wave.
      enter_phase(0, 0, 0, 0);
      queue_tap(1'b1, 1'b1, 16'd1);
      queue_frame(1'b1);
      queue_frame(1'b1);

      // Random phases, cycling through the idling patterns and a spread of settings,
      // the largest register values among them.
      enter_phase(8, 8191, 0, 0);
      queue_random_words(40);
      enter_phase(3, 7, 49, 0);
      queue_random_words(40);
      enter_phase(1, 1, 0, 49);
      queue_random_words(40);
      enter_phase(15, 12, 23, 23);
      queue_random_words(40);

      // Here the sender holds back half way until the block has delivered everything.
      enter_phase(5, 4096, 49, 0);
      queue_random_words(20);
      wait_for_quiet();
      @(negedge clock);
      queue_random_words(20);

      enter_phase(2, 2, 0, 49);
      queue_random_words(40);

      wait_for_quiet();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
